// File: rtl/core/sadq_pkg.sv
// Package with the shared types and constants of the shifting array deque.
package sadq_pkg;

   localparam int CMD_WIDTH    = 3;
   localparam int DATA_WIDTH   = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int RESULT_LIMIT = 16;

   localparam logic [CMD_WIDTH-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_DUMP       = 3'd4;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK,
      OP_DUMP,
      OP_NOP
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_DONE,
      STATUS_FULL,
      STATUS_EMPTY,
      STATUS_ELEMENT
   } status_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_DUMP
   } back_state_type;

   typedef struct packed {
      op_type                       op;
      logic signed [DATA_WIDTH-1:0] value;
   } sadq_cmd_type;

endpackage

// File: rtl/core/sadq_req_if.sv
// Request channel interface carrying deque commands and push values.
interface sadq_req_if import sadq_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [CMD_WIDTH-1:0]         cmd;
   logic signed [DATA_WIDTH-1:0] push_value;

   modport source (output valid, cmd, push_value, input ready);
   modport sink (input valid, cmd, push_value, output ready);
endinterface

// File: rtl/core/sadq_rsp_if.sv
// Response channel interface carrying status, dumped elements and the last mark.
interface sadq_rsp_if import sadq_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [STATUS_WIDTH-1:0]      status;
   logic signed [DATA_WIDTH-1:0] element;
   logic                         last;

   modport source (output valid, status, element, last, input ready);
   modport sink (input valid, status, element, last, output ready);
endinterface

// File: rtl/core/sadq_front.sv
// Front end that accepts requests, decodes them and buffers them in a two-entry queue.
module sadq_front import sadq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   sadq_req_if.sink     req,
   output logic         cmd_valid,
   input  logic         cmd_ready,
   output sadq_cmd_type cmd
);

   sadq_cmd_type entries_ff [2];
   logic         wr_ptr_ff;
   logic         wr_ptr_in;
   logic         rd_ptr_ff;
   logic         rd_ptr_in;
   logic [1:0]   fill_ff;
   logic [1:0]   fill_in;
   logic         push;
   logic         pop;
   sadq_cmd_type decoded;

   always_comb begin
      decoded.value = req.push_value;
      case (req.cmd)
         CMD_PUSH_FRONT: decoded.op = OP_PUSH_FRONT;
         CMD_PUSH_BACK:  decoded.op = OP_PUSH_BACK;
         CMD_POP_FRONT:  decoded.op = OP_POP_FRONT;
         CMD_POP_BACK:   decoded.op = OP_POP_BACK;
         CMD_DUMP:       decoded.op = OP_DUMP;
         default:        decoded.op = OP_NOP;
      endcase
   end

   assign req.ready = (fill_ff != 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = entries_ff[rd_ptr_ff];
   assign push      = req.valid && req.ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// File: rtl/core/sadq_back.sv
// Back end that holds the shifting register array and produces the responses.
module sadq_back import sadq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   output logic         cmd_ready,
   input  sadq_cmd_type cmd,
   sadq_rsp_if.source   rsp
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = (CW > 5) ? CW : 5;

   logic signed [DATA_WIDTH-1:0] slots_ff [DEPTH];
   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                count_in;
   logic [IW-1:0]                idx_ff;
   logic [IW-1:0]                idx_in;
   back_state_type               state_ff;
   back_state_type               state_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   status_type                   status_ff;
   status_type                   status_in;
   logic signed [DATA_WIDTH-1:0] element_ff;
   logic signed [DATA_WIDTH-1:0] element_in;
   logic                         last_ff;
   logic                         last_in;
   logic                         out_free;
   logic                         is_empty;
   logic                         is_full;
   logic                         dump_last;
   logic                         shift_up;
   logic                         shift_down;
   logic                         write_back;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CW'(DEPTH));
   assign dump_last = (EW'(idx_ff) + EW'(1) == EW'(count_ff)) ||
                      (EW'(idx_ff) + EW'(1) == EW'(RESULT_LIMIT));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      status_in    = status_ff;
      element_in   = element_ff;
      last_in      = last_ff;
      cmd_ready    = 1'b0;
      shift_up     = 1'b0;
      shift_down   = 1'b0;
      write_back   = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            cmd_ready = out_free;
            if (cmd_valid && out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_DONE;
               element_in   = '0;
               last_in      = 1'b1;
               case (cmd.op)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     if (is_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        count_in   = count_ff + CW'(1);
                        shift_up   = (cmd.op == OP_PUSH_FRONT);
                        write_back = (cmd.op == OP_PUSH_BACK);
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        count_in   = count_ff - CW'(1);
                        shift_down = (cmd.op == OP_POP_FRONT);
                     end
                  end
                  OP_DUMP: begin
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        status_in  = STATUS_ELEMENT;
                        element_in = slots_ff[0];
                        last_in    = (count_ff == CW'(1));
                        if (count_ff != CW'(1)) begin
                           idx_in   = IW'(1);
                           state_in = BACK_DUMP;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         BACK_DUMP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_ELEMENT;
               element_in   = slots_ff[idx_ff];
               last_in      = dump_last;
               idx_in       = idx_ff + IW'(1);
               if (dump_last) begin
                  state_in = BACK_IDLE;
               end
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_slot
      logic signed [DATA_WIDTH-1:0] up_src;
      logic signed [DATA_WIDTH-1:0] down_src;
      logic signed [DATA_WIDTH-1:0] slot_in;

      if (g == 0) begin : g_first
         assign up_src = cmd.value;
      end else begin : g_inner
         assign up_src = slots_ff[g-1];
      end

      if (g == DEPTH - 1) begin : g_top
         assign down_src = slots_ff[g];
      end else begin : g_lower
         assign down_src = slots_ff[g+1];
      end

      always_comb begin
         if (shift_up) begin
            slot_in = up_src;
         end else if (shift_down) begin
            slot_in = down_src;
         end else if (write_back && (count_ff == CW'(g))) begin
            slot_in = cmd.value;
         end else begin
            slot_in = slots_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         slots_ff[g] <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      element_ff <= element_in;
      last_ff    <= last_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.status  = status_ff;
   assign rsp.element = element_ff;
   assign rsp.last    = last_ff;

endmodule

// File: rtl/core/shifting_array_deque_core.sv
// Top level of the shifting array deque: front end, command queue and back end.
// The req channel takes one command per transaction: push front, push back,
// pop front, pop back or dump, with a signed 32-bit push value.
// The rsp channel returns the results: one transaction per push, pop or unknown
// command, and for a dump one transaction per entry from front to back, at most
// sixteen, with last set on the final one; an empty store answers with one
// empty status. A push on a full store reports full and changes nothing.
// An accepted request enters the command queue, then the response register once
// the back end takes it. Pushes and pops sustain one command per cycle while rsp
// is not stalled; a push or pop at the front shifts all slots in parallel.
// A dump holds the back end and reads one index per cycle unless rsp stalls.
// A two-entry command queue between front and back keeps req ready while the
// back end works, so the front end stalls only once that queue is full.
// When rsp is stalled the response register holds its transaction and the
// back end waits; req then backs up through the queue.
// A synchronous reset empties the store and the queue; there is no clearing
// pass, and the block takes commands in the first cycle after reset.
module shifting_array_deque_core import sadq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   sadq_req_if.sink   req,
   sadq_rsp_if.source rsp
);

   logic         cmd_valid;
   logic         cmd_ready;
   sadq_cmd_type cmd;

   sadq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   sadq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp       (rsp)
   );

`ifndef SYNTHESIS
   a_cmd_loads_response : assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd_ready |=> rsp.valid)
      else $error("accepted command did not produce a response");

   a_status_last : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.status != STATUS_ELEMENT) |-> rsp.last)
      else $error("status response without last mark");

   a_status_zero : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.status != STATUS_ELEMENT) |-> (rsp.element == '0))
      else $error("status response with nonzero element");
`endif

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for shifting_array_deque_core with a built-in deque predictor.
`timescale 1ns / 100ps

module tb;
   import sadq_pkg::*;

   localparam int DEPTH         = 16;
   localparam int RANDOM_ITEMS  = 230;
   localparam int IDLE_PERCENT  = 38;
   localparam int HOLD_AFTER    = 60;
   localparam int HOLD_CYCLES   = 80;
   localparam int CALM_FIRST    = 100;
   localparam int CALM_LAST     = 150;
   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_LIMIT   = 4000;

   typedef struct {
      logic [CMD_WIDTH-1:0]  cmd;
      logic [DATA_WIDTH-1:0] value;
      bit                    drain;
   } deque_cmd_type;

   typedef struct {
      status_type            status;
      logic [DATA_WIDTH-1:0] element;
      logic                  last;
   } deque_result_type;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } mix_type;

   logic clock;
   logic reset;

   sadq_req_if req_bus ();
   sadq_rsp_if rsp_bus ();

   shifting_array_deque_core #(.DEPTH(DEPTH)) DUT (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .rsp(rsp_bus)
   );

   deque_cmd_type    cmd_backlog[$];
   deque_result_type pending_results[$];
   deque_cmd_type    offered;
   deque_result_type want;

   logic [DATA_WIDTH-1:0] deque_slots[DEPTH];
   int                    deque_front;
   int                    deque_back;
   bit                    deque_empty;

   int   sent_count;
   int   total_items;
   int   errors;
   int   hold_left;
   bit   hold_done;
   int   quiet_cycles;
   logic calm;

   assign calm = (sent_count >= CALM_FIRST) && (sent_count < CALM_LAST);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic add_result(status_type status, logic [DATA_WIDTH-1:0] element, logic last);
      deque_result_type r;
      r.status  = status;
      r.element = element;
      r.last    = last;
      pending_results.push_back(r);
   endtask

   // Applies one accepted transaction to the deque copy and queues the responses it causes.
   task automatic run_deque_command(deque_cmd_type c);
      int i;
      int count;
      case (c.cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (!deque_empty && deque_front == 0 && deque_back == DEPTH - 1) begin
               add_result(STATUS_FULL, '0, 1'b1);
            end else begin
               if (deque_empty) begin
                  deque_front    = 0;
                  deque_back     = 0;
                  deque_slots[0] = c.value;
                  deque_empty    = 1'b0;
               end else if (c.cmd == CMD_PUSH_FRONT) begin
                  if (deque_front > 0) begin
                     deque_front--;
                     deque_slots[deque_front] = c.value;
                  end else begin
                     for (i = deque_back + 1; i > 0; i--)
                        deque_slots[i] = deque_slots[i-1];
                     deque_slots[0] = c.value;
                     deque_back++;
                  end
               end else begin
                  if (deque_back < DEPTH - 1) begin
                     deque_back++;
                     deque_slots[deque_back] = c.value;
                  end else begin
                     for (i = deque_front; i <= deque_back; i++)
                        deque_slots[i-1] = deque_slots[i];
                     deque_slots[deque_back] = c.value;
                     deque_front--;
                  end
               end
               add_result(STATUS_DONE, '0, 1'b1);
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (deque_empty) begin
               add_result(STATUS_EMPTY, '0, 1'b1);
            end else begin
               if (deque_front == deque_back) begin
                  deque_front = 0;
                  deque_back  = 0;
                  deque_empty = 1'b1;
               end else if (c.cmd == CMD_POP_FRONT) begin
                  deque_front++;
               end else begin
                  deque_back--;
               end
               add_result(STATUS_DONE, '0, 1'b1);
            end
         end
         CMD_DUMP: begin
            if (deque_empty) begin
               add_result(STATUS_EMPTY, '0, 1'b1);
            end else begin
               count = deque_back - deque_front + 1;
               if (count > RESULT_LIMIT)
                  count = RESULT_LIMIT;
               for (i = 0; i < count; i++)
                  add_result(STATUS_ELEMENT, deque_slots[deque_front + i], i == count - 1);
            end
         end
         default: begin
            add_result(STATUS_DONE, '0, 1'b1);
         end
      endcase
   endtask

   task automatic queue_cmd(logic [CMD_WIDTH-1:0] cmd, logic [DATA_WIDTH-1:0] value,
                            bit drain = 1'b0);
      deque_cmd_type c;
      c.cmd   = cmd;
      c.value = value;
      c.drain = drain;
      cmd_backlog.push_back(c);
   endtask

   function automatic logic [CMD_WIDTH-1:0] pick_cmd(mix_type mix);
      int roll;
      int push_cut;
      int pop_cut;
      roll = $urandom_range(99);
      case (mix)
         MIX_FILL: begin
            push_cut = 70;
            pop_cut  = 82;
         end
         MIX_DRAIN: begin
            push_cut = 15;
            pop_cut  = 80;
         end
         default: begin
            push_cut = 45;
            pop_cut  = 80;
         end
      endcase
      if (roll < push_cut)
         return $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      if (roll < pop_cut)
         return $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
      if (roll < 94)
         return CMD_DUMP;
      return CMD_WIDTH'($urandom_range(int'(CMD_DUMP) + 1, (1 << CMD_WIDTH) - 1));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         sent_count    <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            run_deque_command(offered);
            sent_count <= sent_count + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (cmd_backlog.size() != 0 &&
                !(cmd_backlog[0].drain && pending_results.size() != 0) &&
                (calm || hold_left != 0 || $urandom_range(99) >= IDLE_PERCENT)) begin
               offered = cmd_backlog.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.cmd        <= offered.cmd;
               req_bus.push_value <= offered.value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
         hold_done     <= 1'b0;
         errors        <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected response status %0d element %h last %0d", $time,
                        rsp_bus.status, rsp_bus.element, rsp_bus.last);
               errors <= errors + 1;
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.status !== want.status || rsp_bus.element !== want.element ||
                   rsp_bus.last !== want.last) begin
                  $display("%0t: expected status %0d element %h last %0d, got %0d %h %0d",
                           $time, want.status, want.element, want.last,
                           rsp_bus.status, rsp_bus.element, rsp_bus.last);
                  errors <= errors + 1;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (!hold_done && sent_count >= HOLD_AFTER) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("shifting_array_deque_core verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int      n;
      int      len;
      int      k;
      mix_type mix;
      logic [CMD_WIDTH-1:0] c;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = '0;
      req_bus.push_value = '0;
      rsp_bus.ready      = 1'b0;
      deque_slots        = '{default: '0};
      deque_front        = 0;
      deque_back         = 0;
      deque_empty        = 1'b1;

      queue_cmd(CMD_DUMP, $urandom);
      queue_cmd(CMD_POP_FRONT, $urandom);
      queue_cmd(CMD_POP_BACK, $urandom);
      queue_cmd(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
      queue_cmd(CMD_PUSH_FRONT, 32'h8000_0000);
      queue_cmd(CMD_PUSH_BACK, 32'h0000_0000);
      queue_cmd(CMD_PUSH_BACK, 32'hFFFF_FFFF);
      queue_cmd(CMD_DUMP, $urandom);
      queue_cmd(CMD_POP_FRONT, $urandom);
      queue_cmd(CMD_POP_BACK, $urandom);
      queue_cmd(CMD_POP_FRONT, $urandom);
      queue_cmd(CMD_POP_BACK, $urandom);
      queue_cmd(CMD_POP_BACK, $urandom);
      queue_cmd(CMD_PUSH_BACK, $urandom);
      for (k = int'(CMD_DUMP) + 1; k < (1 << CMD_WIDTH); k++)
         queue_cmd(CMD_WIDTH'(k), $urandom);
      queue_cmd(CMD_DUMP, $urandom);
      queue_cmd(CMD_POP_FRONT, $urandom);

      // The first burst is weighted toward pushes to fill the store, so the full and shifting cases show up early.
      n = 0;
      while (n < RANDOM_ITEMS) begin
         if (n == 0) begin
            mix = MIX_FILL;
            len = 24;
         end else begin
            mix = mix_type'($urandom_range(2));
            len = $urandom_range(8, 30);
         end
         for (k = 0; k < len && n < RANDOM_ITEMS; k++) begin
            c = pick_cmd(mix);
            queue_cmd(c, $urandom, n == 0 || n == 120);
            n++;
         end
      end
      total_items = cmd_backlog.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (sent_count != total_items)
         @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (errors == 0)
         $display("shifting_array_deque_core verification clean");
      else
         $display("shifting_array_deque_core verification failed");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/sadq_pkg.sv
rtl/core/sadq_req_if.sv
rtl/core/sadq_rsp_if.sv
rtl/core/sadq_front.sv
rtl/core/sadq_back.sv
rtl/core/shifting_array_deque_core.sv
tb/sv/tb.sv
